// ===== design/npcp_pkg.sv =====
package npcp_pkg;

    localparam int MAX_VERTEX_INDEX = 65535;
    localparam int CNT_W            = 17;
    localparam int DEPTH_FRAC       = 16;
    localparam int DEPTH_ONE        = 1 << DEPTH_FRAC;
    localparam int TBITS            = 30;
    localparam int DIV_STEPS        = 32;
    localparam int DIV_CNT_W        = $clog2(DIV_STEPS + 1);
    localparam int CFG_IDX_W        = 8;
    localparam int LERP_CHANS       = 8;

    localparam logic signed [31:0] NEAR_RESET   = 32'sd65536;
    localparam logic signed [31:0] FAR_RESET    = 32'sd655360000;
    localparam logic signed [31:0] XSCALE_RESET = 32'sd65536;
    localparam logic signed [31:0] YSCALE_RESET = 32'sd65536;
    localparam logic signed [31:0] SAT_MAX      = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN      = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEAR_PLANE = 8'd0,
        CFG_FAR_PLANE  = 8'd1,
        CFG_X_SCALE    = 8'd2,
        CFG_Y_SCALE    = 8'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OP_X     = 2'd0,
        OP_Y     = 2'd1,
        OP_DEPTH = 2'd2
    } proj_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLIP_CHK,
        S_CLIP_DIV,
        S_CLIP_LERP,
        S_CLIP_PUT,
        S_CLIP_CUR,
        S_PRJ_MUL,
        S_PRJ_START,
        S_PRJ_WAIT,
        S_EMIT_CHK,
        S_EMIT_V
    } npcp_state_t;

    typedef struct packed {
        logic               start_batch;
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_z;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
        logic [7:0]         red_in;
        logic [7:0]         green_in;
        logic [7:0]         blue_in;
        logic [7:0]         alpha_in;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic [16:0]        depth_out;
        logic signed [31:0] out_u;
        logic signed [31:0] out_v;
        logic [7:0]         red_out;
        logic [7:0]         green_out;
        logic [7:0]         blue_out;
        logic [7:0]         alpha_out;
        logic [15:0]        vertex_number;
        logic               last_of_run;
    } out_beat_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic [7:0]         r;
        logic [7:0]         g;
        logic [7:0]         b;
        logic [7:0]         a;
    } vert_t;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic [16:0]        depth;
    } proj_t;

    typedef struct packed {
        logic       store_shift;
        logic       clr_count;
        logic       rotate;
        logic       clip_start;
        logic       lerp_mul;
        logic [2:0] lerp_chan;
        logic       commit_cut;
        logic       commit_cur;
        logic       proj_mul;
        logic       proj_start;
        logic       proj_write;
        proj_op_t   op;
        logic [1:0] idx;
        logic       emit_load;
        logic       emit_last;
    } npcp_cmd_t;

    typedef struct packed {
        logic cur_in;
        logic prev_in;
        logic div_busy;
        logic div_done;
        logic out_free;
        logic idx_ovf;
        logic last_near;
    } npcp_stat_t;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        logic [32:0] r;
        r = v[32] ? 33'(-v) : 33'(v);
        return r;
    endfunction

endpackage

// ===== design/npcp_div.sv =====
module npcp_div import npcp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [32:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [31:0] quotient
);

    // Restoring division, one quotient bit per cycle. The upper half of the
    // dividend must be below the divisor so that the quotient fits 32 bits.
    logic [32:0]          rem_reg, rem_next;
    logic [31:0]          dvd_reg, dvd_next;
    logic [31:0]          quo_reg, quo_next;
    logic [32:0]          dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [33:0]          trial;
    logic                 fits;

    assign trial = {rem_reg, dvd_reg[31]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = {1'b0, dividend[63:32]};
            dvd_next  = dividend[31:0];
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? 33'(trial - {1'b0, dvs_reg}) : trial[32:0];
            dvd_next = {dvd_reg[30:0], 1'b0};
            quo_next = {quo_reg[30:0], fits};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/npcp_dp.sv =====
module npcp_dp import npcp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  npcp_cmd_t            cmd,
    output npcp_stat_t           stat,
    input  in_beat_t             s_data,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 m_ready,
    output logic                 m_valid,
    output out_beat_t            m_data
);

    logic signed [31:0] near_reg, far_reg, xs_reg, ys_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_reg <= NEAR_RESET;
            far_reg  <= FAR_RESET;
            xs_reg   <= XSCALE_RESET;
            ys_reg   <= YSCALE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_NEAR_PLANE: near_reg <= $signed(cfg_data);
                CFG_FAR_PLANE:  far_reg  <= $signed(cfg_data);
                CFG_X_SCALE:    xs_reg   <= $signed(cfg_data);
                CFG_Y_SCALE:    ys_reg   <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // Triangle store as a three-tap line: tap 0 is the current vertex of the
    // edge under test and tap 2 the previous one; a rotate moves to the next edge.
    vert_t st_reg [3];
    vert_t in_vert, cur_v, prev_v;

    assign in_vert.x = s_data.cam_x;
    assign in_vert.y = s_data.cam_y;
    assign in_vert.z = s_data.cam_z;
    assign in_vert.u = s_data.tex_u;
    assign in_vert.v = s_data.tex_v;
    assign in_vert.r = s_data.red_in;
    assign in_vert.g = s_data.green_in;
    assign in_vert.b = s_data.blue_in;
    assign in_vert.a = s_data.alpha_in;

    always_ff @(posedge aclk) begin
        if (cmd.store_shift || cmd.rotate) begin
            st_reg[0] <= st_reg[1];
            st_reg[1] <= st_reg[2];
            st_reg[2] <= cmd.store_shift ? in_vert : st_reg[0];
        end
    end

    assign cur_v  = st_reg[0];
    assign prev_v = st_reg[2];

    assign stat.cur_in  = $signed(cur_v.z) >= near_reg;
    assign stat.prev_in = $signed(prev_v.z) >= near_reg;

    // Clip parameter t = |near - P.z| * 2^30 / |C.z - P.z|.
    logic signed [32:0] dz, dn;
    assign dz = 33'($signed(cur_v.z)) - 33'($signed(prev_v.z));
    assign dn = 33'(near_reg) - 33'($signed(prev_v.z));

    logic [63:0] div_dvd, pdvd;
    logic [32:0] div_dvs, pdvs;
    logic [31:0] div_q;
    logic        div_busy, div_done;

    assign div_dvd = cmd.clip_start ? {1'b0, mag33(dn), 30'b0} : pdvd;
    assign div_dvs = cmd.clip_start ? mag33(dz) : pdvs;

    npcp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.clip_start | cmd.proj_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign stat.div_busy = div_busy;
    assign stat.div_done = div_done;

    // Interpolation, one channel per cycle: multiply, then round and add.
    logic signed [32:0] la, lb, ld;
    logic [63:0]        lprod;
    logic [63:0]        prod_reg;
    logic signed [31:0] la_reg;
    logic               lneg_reg;
    logic [2:0]         lch_reg;
    logic               lv_reg;
    logic [63:0]        lrnd, lsum;
    logic [33:0]        lq;
    logic signed [33:0] lres;
    vert_t              cut_reg;

    always_comb begin
        case (cmd.lerp_chan)
            3'd0: begin la = 33'($signed(prev_v.x)); lb = 33'($signed(cur_v.x)); end
            3'd1: begin la = 33'($signed(prev_v.y)); lb = 33'($signed(cur_v.y)); end
            3'd2: begin la = 33'($signed(prev_v.u)); lb = 33'($signed(cur_v.u)); end
            3'd3: begin la = 33'($signed(prev_v.v)); lb = 33'($signed(cur_v.v)); end
            3'd4: begin la = $signed({25'b0, prev_v.r}); lb = $signed({25'b0, cur_v.r}); end
            3'd5: begin la = $signed({25'b0, prev_v.g}); lb = $signed({25'b0, cur_v.g}); end
            3'd6: begin la = $signed({25'b0, prev_v.b}); lb = $signed({25'b0, cur_v.b}); end
            default: begin la = $signed({25'b0, prev_v.a}); lb = $signed({25'b0, cur_v.a}); end
        endcase
    end

    assign ld    = lb - la;
    assign lprod = 64'(mag33(ld)) * 64'(div_q[TBITS:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lv_reg <= 1'b0;
        end else begin
            lv_reg <= cmd.lerp_mul;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.lerp_mul) begin
            prod_reg <= lprod;
            la_reg   <= la[31:0];
            lneg_reg <= ld[32];
            lch_reg  <= cmd.lerp_chan;
        end
    end

    // Positions round to nearest, ties away from zero; colors round down.
    always_comb begin
        if (!lch_reg[2]) begin
            lrnd = 64'(1) << (TBITS - 1);
        end else if (lneg_reg) begin
            lrnd = (64'(1) << TBITS) - 64'(1);
        end else begin
            lrnd = '0;
        end
        lsum = prod_reg + lrnd;
        lq   = lsum[63:TBITS];
        lres = lneg_reg ? 34'(la_reg) - $signed(lq) : 34'(la_reg) + $signed(lq);
    end

    always_ff @(posedge aclk) begin
        if (cmd.clip_start) begin
            cut_reg.z <= near_reg;
        end
        if (lv_reg) begin
            case (lch_reg)
                3'd0:    cut_reg.x <= lres[31:0];
                3'd1:    cut_reg.y <= lres[31:0];
                3'd2:    cut_reg.u <= lres[31:0];
                3'd3:    cut_reg.v <= lres[31:0];
                3'd4:    cut_reg.r <= lres[7:0];
                3'd5:    cut_reg.g <= lres[7:0];
                3'd6:    cut_reg.b <= lres[7:0];
                default: cut_reg.a <= lres[7:0];
            endcase
        end
    end

    // Clipped polygon and the projection of each of its vertices.
    vert_t poly_reg [4];
    proj_t proj_reg [4];
    vert_t pv;
    proj_t pp;

    assign pv = poly_reg[cmd.idx];
    assign pp = proj_reg[cmd.idx];

    logic signed [31:0] mul_src, mul_scl;
    logic signed [63:0] num_reg;
    logic signed [32:0] den_reg;
    logic [63:0]        mag_n;
    logic [32:0]        mag_d;
    logic               p_force, p_neg;
    logic signed [31:0] p_fval;
    logic               force_reg, neg_reg;
    logic signed [31:0] fval_reg;
    logic signed [31:0] xy_res;
    logic [16:0]        dep_res;

    assign mul_src = (cmd.op == OP_Y) ? $signed(pv.y) : $signed(pv.x);
    assign mul_scl = (cmd.op == OP_Y) ? ys_reg : xs_reg;

    always_ff @(posedge aclk) begin
        if (cmd.proj_mul) begin
            if (cmd.op == OP_DEPTH) begin
                num_reg <= 64'(33'($signed(pv.z)) - 33'(near_reg));
                den_reg <= 33'(far_reg) - 33'(near_reg);
            end else begin
                num_reg <= 64'(mul_src) * 64'(mul_scl);
                den_reg <= 33'($signed(pv.z));
            end
        end
    end

    assign mag_n = num_reg[63] ? 64'(-num_reg) : 64'(num_reg);
    assign mag_d = mag33(den_reg);
    assign p_neg = num_reg[63] ^ den_reg[32];

    always_comb begin
        p_force = 1'b0;
        p_fval  = '0;
        pdvd    = mag_n;
        pdvs    = mag_d;
        if (cmd.op == OP_DEPTH) begin
            pdvd = mag_n << DEPTH_FRAC;
            if (den_reg == '0) begin
                p_force = 1'b1;
                p_fval  = (num_reg > 64'sd0) ? 32'(DEPTH_ONE) : '0;
            end else if (num_reg == '0 || num_reg[63] != den_reg[32]) begin
                p_force = 1'b1;
            end else if (mag_n >= 64'(mag_d)) begin
                p_force = 1'b1;
                p_fval  = 32'(DEPTH_ONE);
            end
        end else begin
            if (den_reg == '0) begin
                p_force = 1'b1;
                if (num_reg > 64'sd0) begin
                    p_fval = SAT_MAX;
                end else if (num_reg < 64'sd0) begin
                    p_fval = SAT_MIN;
                end
            end else if ({1'b0, mag_n[63:32]} >= mag_d) begin
                p_force = 1'b1;
                p_fval  = p_neg ? SAT_MIN : SAT_MAX;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.proj_start) begin
            force_reg <= p_force;
            fval_reg  <= p_fval;
            neg_reg   <= p_neg;
        end
    end

    always_comb begin
        if (force_reg) begin
            xy_res = fval_reg;
        end else if (neg_reg) begin
            xy_res = (div_q > 32'h8000_0000) ? SAT_MIN : $signed(32'(-div_q));
        end else begin
            xy_res = div_q[31] ? SAT_MAX : $signed(div_q);
        end
        dep_res = force_reg ? fval_reg[16:0] : div_q[16:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit_cut) begin
            poly_reg[cmd.idx] <= cut_reg;
        end else if (cmd.commit_cur) begin
            poly_reg[cmd.idx] <= cur_v;
        end
        if (cmd.proj_write) begin
            case (cmd.op)
                OP_X:     proj_reg[cmd.idx].sx    <= xy_res;
                OP_Y:     proj_reg[cmd.idx].sy    <= xy_res;
                OP_DEPTH: proj_reg[cmd.idx].depth <= dep_res;
                default: ;
            endcase
        end
    end

    // Vertex counter and output register.
    logic [CNT_W-1:0] cnt_reg;
    logic             m_valid_reg;
    out_beat_t        m_data_reg;

    assign stat.out_free  = !m_valid_reg || m_ready;
    assign stat.idx_ovf   = (18'(cnt_reg) + 18'd3) > 18'(MAX_VERTEX_INDEX);
    assign stat.last_near = (18'(cnt_reg) + 18'd4) > 18'(MAX_VERTEX_INDEX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr_count) begin
                cnt_reg <= '0;
            end else if (cmd.emit_load) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.emit_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            m_data_reg.screen_x      <= pp.sx;
            m_data_reg.screen_y      <= pp.sy;
            m_data_reg.depth_out     <= pp.depth;
            m_data_reg.out_u         <= pv.u;
            m_data_reg.out_v         <= pv.v;
            m_data_reg.red_out       <= pv.r;
            m_data_reg.green_out     <= pv.g;
            m_data_reg.blue_out      <= pv.b;
            m_data_reg.alpha_out     <= pv.a;
            m_data_reg.vertex_number <= cnt_reg[15:0];
            m_data_reg.last_of_run   <= cmd.emit_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== design/npcp_ctrl.sv =====
module npcp_ctrl import npcp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       start_batch,
    output logic       s_ready,
    input  npcp_stat_t stat,
    output npcp_cmd_t  cmd
);

    npcp_state_t state_reg, state_next;
    logic [1:0]  pos_reg, pos_next;
    logic [1:0]  edge_reg, edge_next;
    logic [2:0]  n_reg, n_next;
    logic [3:0]  chan_reg, chan_next;
    logic [1:0]  j_reg, j_next;
    proj_op_t    op_reg, op_next;
    logic [1:0]  k_reg, k_next;
    logic [1:0]  v_reg, v_next;

    logic       edge_adv, tri_adv, tri_last;
    logic [2:0] n_after;
    logic [1:0] pos_eff;

    assign edge_adv = (state_reg == S_CLIP_CHK && stat.cur_in == stat.prev_in && !stat.cur_in)
                   || (state_reg == S_CLIP_PUT && !stat.cur_in)
                   || (state_reg == S_CLIP_CUR);
    assign tri_adv  = (state_reg == S_EMIT_CHK && stat.idx_ovf)
                   || (state_reg == S_EMIT_V && stat.out_free && v_reg == 2'd2);
    assign tri_last = ({1'b0, k_reg} + 3'd1) >= (n_reg - 3'd1);
    assign n_after  = (state_reg == S_CLIP_CHK) ? n_reg : n_reg + 3'd1;

    always_comb begin : next_state
        state_next = state_reg;
        pos_next   = pos_reg;
        edge_next  = edge_reg;
        n_next     = n_reg;
        chan_next  = chan_reg;
        j_next     = j_reg;
        op_next    = op_reg;
        k_next     = k_reg;
        v_next     = v_reg;
        pos_eff    = start_batch ? 2'd0 : pos_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (pos_eff == 2'd2) begin
                        pos_next   = 2'd0;
                        edge_next  = 2'd0;
                        n_next     = 3'd0;
                        state_next = S_CLIP_CHK;
                    end else begin
                        pos_next = pos_eff + 2'd1;
                    end
                end
            end
            S_CLIP_CHK: begin
                if (stat.cur_in != stat.prev_in) begin
                    state_next = S_CLIP_DIV;
                end else if (stat.cur_in) begin
                    state_next = S_CLIP_CUR;
                end
            end
            S_CLIP_DIV: begin
                if (stat.div_done) begin
                    chan_next  = 4'd0;
                    state_next = S_CLIP_LERP;
                end
            end
            S_CLIP_LERP: begin
                if (chan_reg == 4'(LERP_CHANS)) begin
                    state_next = S_CLIP_PUT;
                end else begin
                    chan_next = chan_reg + 4'd1;
                end
            end
            S_CLIP_PUT: begin
                n_next = n_reg + 3'd1;
                if (stat.cur_in) begin
                    state_next = S_CLIP_CUR;
                end
            end
            S_CLIP_CUR: begin
                n_next = n_reg + 3'd1;
            end
            S_PRJ_MUL: begin
                state_next = S_PRJ_START;
            end
            S_PRJ_START: begin
                state_next = S_PRJ_WAIT;
            end
            S_PRJ_WAIT: begin
                if (stat.div_done) begin
                    case (op_reg)
                        OP_X: begin
                            op_next    = OP_Y;
                            state_next = S_PRJ_MUL;
                        end
                        OP_Y: begin
                            op_next    = OP_DEPTH;
                            state_next = S_PRJ_MUL;
                        end
                        default: begin
                            op_next = OP_X;
                            if (({1'b0, j_reg} + 3'd1) == n_reg) begin
                                k_next     = 2'd1;
                                v_next     = 2'd0;
                                state_next = S_EMIT_CHK;
                            end else begin
                                j_next     = j_reg + 2'd1;
                                state_next = S_PRJ_MUL;
                            end
                        end
                    endcase
                end
            end
            S_EMIT_CHK: begin
                if (!stat.idx_ovf) begin
                    v_next     = 2'd0;
                    state_next = S_EMIT_V;
                end
            end
            S_EMIT_V: begin
                if (stat.out_free && v_reg != 2'd2) begin
                    v_next = v_reg + 2'd1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (edge_adv) begin
            if (edge_reg == 2'd2) begin
                if (n_after >= 3'd3) begin
                    j_next     = 2'd0;
                    op_next    = OP_X;
                    state_next = S_PRJ_MUL;
                end else begin
                    state_next = S_IDLE;
                end
            end else begin
                edge_next  = edge_reg + 2'd1;
                state_next = S_CLIP_CHK;
            end
        end
        if (tri_adv) begin
            if (tri_last) begin
                state_next = S_IDLE;
            end else begin
                k_next     = k_reg + 2'd1;
                state_next = S_EMIT_CHK;
            end
        end
    end

    always_comb begin : outputs
        cmd     = '0;
        s_ready = 1'b0;
        cmd.op  = op_reg;
        cmd.rotate = edge_adv;
        case (state_reg)
            S_IDLE: begin
                s_ready         = 1'b1;
                cmd.store_shift = s_valid;
                cmd.clr_count   = s_valid && start_batch;
            end
            S_CLIP_CHK: begin
                cmd.clip_start = stat.cur_in != stat.prev_in;
            end
            S_CLIP_LERP: begin
                cmd.lerp_mul  = chan_reg < 4'(LERP_CHANS);
                cmd.lerp_chan = chan_reg[2:0];
            end
            S_CLIP_PUT: begin
                cmd.commit_cut = 1'b1;
                cmd.idx        = n_reg[1:0];
            end
            S_CLIP_CUR: begin
                cmd.commit_cur = 1'b1;
                cmd.idx        = n_reg[1:0];
            end
            S_PRJ_MUL: begin
                cmd.proj_mul = 1'b1;
                cmd.idx      = j_reg;
            end
            S_PRJ_START: begin
                cmd.proj_start = 1'b1;
                cmd.idx        = j_reg;
            end
            S_PRJ_WAIT: begin
                cmd.proj_write = stat.div_done;
                cmd.idx        = j_reg;
            end
            S_EMIT_V: begin
                cmd.emit_load = stat.out_free;
                cmd.emit_last = (v_reg == 2'd2) && (tri_last || stat.last_near);
                case (v_reg)
                    2'd0:    cmd.idx = 2'd0;
                    2'd1:    cmd.idx = k_reg;
                    default: cmd.idx = k_reg + 2'd1;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pos_reg   <= 2'd0;
            edge_reg  <= 2'd0;
            n_reg     <= 3'd0;
            chan_reg  <= 4'd0;
            j_reg     <= 2'd0;
            op_reg    <= OP_X;
            k_reg     <= 2'd1;
            v_reg     <= 2'd0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            edge_reg  <= edge_next;
            n_reg     <= n_next;
            chan_reg  <= chan_next;
            j_reg     <= j_next;
            op_reg    <= op_next;
            k_reg     <= k_next;
            v_reg     <= v_next;
        end
    end

`ifndef ASSERT_OFF
    a_emit_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_load |-> stat.out_free)
        else $error("vertex loaded into a full output register");

    a_div_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.clip_start || cmd.proj_start) |-> !stat.div_busy)
        else $error("divider started while busy");

    a_poly_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= 3'd4)
        else $error("clipped polygon exceeds four vertices");

    a_lerp_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLIP_LERP && chan_reg == 4'd0) |-> $past(stat.div_done))
        else $error("interpolation began before the clip divide finished");
`endif

endmodule

// ===== design/near_plane_clip_and_project.sv =====
// Near-plane clip and perspective projection of camera-space triangles.
// Vertices arrive as beats on the s_ channel (valid/ready). The first two
// beats of a triangle are taken in the idle state. The third triggers the
// clip of the triangle against the near clip depth and the projection of the
// resulting polygon, during which s_ready is low. Each output beat on the
// m_ channel is one projected vertex; up to six leave per triangle, and the
// last one carries last_of_run.
// Work per triangle: each cut edge needs one 32-step divide and the
// interpolation of eight channels, each polygon vertex three 32-step
// divides for x, y and depth through the single shared divider; then
// each emitted vertex is loaded into the output register in turn.
// The output register lets the block accept the next vertex while the last
// result still waits; a stalled m_ready only holds the emission loop.
// Configuration writes (cfg_valid/cfg_ready, always ready) go to the
// near, far and scale registers and are meant for idle periods.
// Synchronous active-low reset restores the register defaults, empties
// the output register and restarts triangle assembly and vertex numbering.
module near_plane_clip_and_project import npcp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_beat_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_beat_t            m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    npcp_cmd_t  cmd;
    npcp_stat_t stat;

    // Registers accept a write in any cycle.
    assign cfg_ready = 1'b1;

    // The controller sequences assembly, clipping, projection and emission.
    npcp_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .start_batch (s_data.start_batch),
        .s_ready     (s_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    // The datapath holds the store, polygon, divider and output register.
    npcp_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule
